/* sv/grid_obstacle_explorer_assert.svh */
`ifndef GRID_OBSTACLE_EXPLORER_ASSERT_SVH
`define GRID_OBSTACLE_EXPLORER_ASSERT_SVH

// same-cycle implication, checked only out of reset
`define GOX_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gox check failed");

// next-cycle implication, checked only out of reset
`define GOX_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gox check failed");

`endif

/* sv/gox_pkg.sv */
package gox_pkg;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_EXPLORE,
        PH_FINAL,
        PH_DONE
    } phase_t;

    typedef enum logic [3:0] {
        T_IDLE,
        T_START2,
        T_SCAN_RD,
        T_SCAN_CHK,
        T_INIT,
        T_GO,
        T_SEARCH,
        T_EMIT_RD,
        T_EMIT,
        T_FIN
    } top_state_t;

    typedef enum logic [1:0] {
        SR_IDLE,
        SR_EXPAND,
        SR_CHECK,
        SR_POP
    } srch_state_t;

    localparam logic [1:0] MAP_UNKNOWN  = 2'd0;
    localparam logic [1:0] MAP_OBSTACLE = 2'd1;
    localparam logic [1:0] MAP_FREE     = 2'd2;
    localparam logic [1:0] MAP_UNREACH  = 2'd3;

    localparam logic [1:0] RPT_NONE     = 2'd0;
    localparam logic [1:0] RPT_OBSTACLE = 2'd1;
    localparam logic [1:0] RPT_FREE     = 2'd2;

    localparam logic [1:0] DIR_DOWN     = 2'd0;
    localparam logic [1:0] HEAD_UP      = 2'd1;
    localparam logic [1:0] DIR_RIGHT    = 2'd2;
    localparam logic [1:0] DIR_LEFT     = 2'd3;

    localparam logic       OP_START     = 1'b0;

    localparam logic [11:0] THRESH_RESET = 12'd80;

    typedef struct packed {
        logic done;
        logic found;
    } srch_stat_t;

    typedef struct packed {
        logic       ok;
        logic [7:0] loc;
    } nbr_t;

    // direction order: down, up, right, left
    function automatic nbr_t neighbor(input logic [7:0] c, input logic [1:0] d,
                                      input int side);
        nbr_t       r;
        logic       ledge;
        logic       redge;
        logic [8:0] c9;
        logic [8:0] s9;
        logic [8:0] n9;
        ledge = 1'b0;
        redge = 1'b0;
        c9    = {1'b0, c};
        s9    = 9'(side);
        n9    = c9;
        for (int k = 0; k < 16; k++)
        begin
            if (k < side)
            begin
                if (c9 == 9'(k * side))
                    ledge = 1'b1;
                if (c9 == 9'(k * side + side - 1))
                    redge = 1'b1;
            end
        end
        unique case (d)
            DIR_DOWN:
            begin
                r.ok = (c9 + s9) < 9'(side * side);
                n9   = c9 + s9;
            end
            HEAD_UP:
            begin
                r.ok = c9 >= s9;
                n9   = c9 - s9;
            end
            DIR_RIGHT:
            begin
                r.ok = !redge;
                n9   = c9 + 9'd1;
            end
            default:
            begin
                r.ok = !ledge;
                n9   = c9 - 9'd1;
            end
        endcase
        r.loc = n9[7:0];
        return r;
    endfunction

endpackage

/* sv/gox_ram.sv */
module gox_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/gox_search.sv */
module gox_search #(
    parameter int GRID_SIDE = 4,
    localparam int CELLS = GRID_SIDE * GRID_SIDE,
    localparam int CW = $clog2(CELLS)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [CW-1:0]          from_cell,
    input  logic [CW-1:0]          to_cell,
    input  logic                   init_we,
    input  logic [CW-1:0]          init_addr,
    input  logic                   init_blk,
    input  logic [CW-1:0]          sd_addr,
    output logic [1:0]             sd_dir,
    output gox_pkg::srch_stat_t    stat
);

    gox_pkg::srch_state_t state_reg, state_next;
    logic [CW-1:0] top_cell_reg, top_cell_next;
    logic [2:0]    top_dir_reg, top_dir_next;
    logic [CW:0]   depth_reg, depth_next;
    logic [CW-1:0] to_reg, to_next;
    logic [CW-1:0] nb_reg, nb_next;
    logic [1:0]    try_reg, try_next;
    gox_pkg::srch_stat_t stat_reg, stat_next;

    logic          blk_we;
    logic [CW-1:0] blk_waddr;
    logic          blk_wdata;
    logic [CW-1:0] blk_raddr;
    logic          blk_rdata;
    logic          eng_blk_we;
    logic [CW-1:0] eng_blk_waddr;
    logic          eng_blk_wdata;

    logic          stk_we;
    logic [CW-1:0] stk_waddr;
    logic [CW+2:0] stk_wdata;
    logic [CW-1:0] stk_raddr;
    logic [CW+2:0] stk_rdata;

    logic          sd_we;
    logic [1:0]    sd_wdata;

    gox_pkg::nbr_t nb;

    assign nb = gox_pkg::neighbor(8'(top_cell_reg), top_dir_reg[1:0], GRID_SIDE);

    gox_ram #(.WIDTH(1), .DEPTH(CELLS)) u_blk (
        .clk   (clk),
        .we    (blk_we),
        .waddr (blk_waddr),
        .wdata (blk_wdata),
        .raddr (blk_raddr),
        .rdata (blk_rdata)
    );

    gox_ram #(.WIDTH(CW + 3), .DEPTH(CELLS)) u_stk (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    gox_ram #(.WIDTH(2), .DEPTH(CELLS)) u_sd (
        .clk   (clk),
        .we    (sd_we),
        .waddr (top_cell_reg),
        .wdata (sd_wdata),
        .raddr (sd_addr),
        .rdata (sd_dir)
    );

    // blocked map is loaded by the caller while idle
    always_comb
    begin
        if (init_we)
        begin
            blk_we    = 1'b1;
            blk_waddr = init_addr;
            blk_wdata = init_blk;
        end
        else
        begin
            blk_we    = eng_blk_we;
            blk_waddr = eng_blk_waddr;
            blk_wdata = eng_blk_wdata;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gox_pkg::SR_IDLE:
                if (start && (from_cell != to_cell))
                    state_next = gox_pkg::SR_EXPAND;
            gox_pkg::SR_EXPAND:
                priority if (top_dir_reg[2])
                    state_next = (depth_reg == (CW+1)'(1)) ? gox_pkg::SR_IDLE
                                                           : gox_pkg::SR_POP;
                else if (nb.ok)
                    state_next = gox_pkg::SR_CHECK;
            gox_pkg::SR_CHECK:
                if (!blk_rdata && (nb_reg == to_reg))
                    state_next = gox_pkg::SR_IDLE;
                else
                    state_next = gox_pkg::SR_EXPAND;
            gox_pkg::SR_POP:
                state_next = gox_pkg::SR_EXPAND;
            default:
                state_next = gox_pkg::SR_IDLE;
        endcase
    end

    always_comb
    begin
        top_cell_next = top_cell_reg;
        top_dir_next  = top_dir_reg;
        depth_next    = depth_reg;
        to_next       = to_reg;
        nb_next       = nb_reg;
        try_next      = try_reg;
        stat_next     = '0;
        eng_blk_we    = 1'b0;
        eng_blk_waddr = top_cell_reg;
        eng_blk_wdata = 1'b0;
        blk_raddr     = nb_reg;
        stk_we        = 1'b0;
        stk_waddr     = CW'(depth_reg - (CW+1)'(1));
        stk_wdata     = {top_cell_reg, top_dir_reg};
        stk_raddr     = CW'(depth_reg - (CW+1)'(2));
        sd_we         = 1'b0;
        sd_wdata      = try_reg;
        unique case (state_reg)
            gox_pkg::SR_IDLE:
                if (start)
                begin
                    to_next       = to_cell;
                    top_cell_next = from_cell;
                    top_dir_next  = 3'd0;
                    depth_next    = (CW+1)'(1);
                    if (from_cell == to_cell)
                        stat_next = '{done: 1'b1, found: 1'b1};
                    else
                    begin
                        eng_blk_we    = 1'b1;
                        eng_blk_waddr = from_cell;
                        eng_blk_wdata = 1'b1;
                    end
                end
            gox_pkg::SR_EXPAND:
                if (top_dir_reg[2])
                begin
                    eng_blk_we = 1'b1;
                    depth_next = depth_reg - (CW+1)'(1);
                    if (depth_reg == (CW+1)'(1))
                        stat_next = '{done: 1'b1, found: 1'b0};
                end
                else
                begin
                    top_dir_next = top_dir_reg + 3'd1;
                    if (nb.ok)
                    begin
                        nb_next   = CW'(nb.loc);
                        try_next  = top_dir_reg[1:0];
                        blk_raddr = CW'(nb.loc);
                    end
                end
            gox_pkg::SR_CHECK:
                if (!blk_rdata)
                begin
                    sd_we = 1'b1;
                    if (nb_reg == to_reg)
                        stat_next = '{done: 1'b1, found: 1'b1};
                    else if (depth_reg < (CW+1)'(CELLS))
                    begin
                        eng_blk_we    = 1'b1;
                        eng_blk_waddr = nb_reg;
                        eng_blk_wdata = 1'b1;
                        stk_we        = 1'b1;
                        top_cell_next = nb_reg;
                        top_dir_next  = 3'd0;
                        depth_next    = depth_reg + (CW+1)'(1);
                    end
                end
            gox_pkg::SR_POP:
            begin
                top_cell_next = stk_rdata[CW+2:3];
                top_dir_next  = stk_rdata[2:0];
            end
            default:
                stat_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gox_pkg::SR_IDLE;
            stat_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            stat_reg  <= stat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_cell_reg <= top_cell_next;
        top_dir_reg  <= top_dir_next;
        depth_reg    <= depth_next;
        to_reg       <= to_next;
        nb_reg       <= nb_next;
        try_reg      <= try_next;
    end

    assign stat = stat_reg;

endmodule

/* sv/grid_obstacle_explorer.sv */
// A reply that moves on without a new plan passes T_EMIT_RD, T_EMIT and T_FIN;
// a new plan scans the cells (T_SCAN_RD, T_SCAN_CHK), loads the blocked map (T_INIT) and
// then runs the depth-first search; every reply is loaded to the output from T_FIN.
// Throughput: one request at a time; the next request is taken once the previous one
// has its result loaded, while that result may still wait at the output.
// Reset clears map valid bits, phase and cells, and sets heading to up and threshold to 80.
module grid_obstacle_explorer #(
    parameter int GRID_SIDE = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [3:0]  start_cell,
    input  logic [3:0]  goal_cell,
    input  logic [11:0] distance,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  reported_cell,
    output logic [1:0]  reported_status,
    output logic [3:0]  probe_cell,
    output logic        probe_valid,
    output logic [1:0]  heading,
    output logic        done_res,
    output logic        goal_unreachable,
    input  logic        cfg_we,
    input  logic [11:0] cfg_wdata
);

    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int CW    = $clog2(CELLS);
    localparam int MW    = CW + 5;

    function automatic logic [CW-1:0] cell_mod(input logic [3:0] v);
        logic [MW-1:0] t;
        t = MW'(v);
        for (int k = 0; k < 4; k++)
        begin
            if (t >= MW'(CELLS))
                t = t - MW'(CELLS);
        end
        return CW'(t);
    endfunction

    gox_pkg::top_state_t state_reg, state_next;
    gox_pkg::phase_t     phase_reg, phase_next;
    logic [CW-1:0] cur_reg, cur_next;
    logic [CW-1:0] tgt_reg, tgt_next;
    logic [CW-1:0] goal_reg, goal_next;
    logic [1:0]    head_reg, head_next;
    logic          unreach_reg, unreach_next;
    logic [11:0]   thr_reg;
    logic [CW-1:0] scan_reg, scan_next;
    logic [CW:0]   init_reg, init_next;
    logic          ipend_reg, ipend_next;
    logic [CW-1:0] iaddr_reg;
    logic          final_reg, final_next;
    logic [3:0]    rcell_reg, rcell_next;
    logic [1:0]    rstat_reg, rstat_next;
    logic [3:0]    pcell_reg, pcell_next;
    logic          pvalid_reg, pvalid_next;
    logic [1:0]    phead_reg, phead_next;

    logic          out_valid_reg, out_valid_next;
    logic [3:0]    o_rcell_reg;
    logic [1:0]    o_rstat_reg;
    logic [3:0]    o_pcell_reg;
    logic          o_pvalid_reg;
    logic [1:0]    o_phead_reg;
    logic          o_done_reg;
    logic          o_unreach_reg;
    logic          load_out;

    logic [CELLS-1:0] mvld_reg;
    logic          mrdv_reg;
    logic          map_we;
    logic [CW-1:0] map_waddr;
    logic [1:0]    map_wdata;
    logic [CW-1:0] map_raddr;
    logic [1:0]    map_rdata;
    logic [1:0]    mval;

    logic          srch_start;
    logic [1:0]    sd_dir;
    gox_pkg::srch_stat_t srch;

    logic          accept;
    logic          active;
    logic          out_free;
    gox_pkg::nbr_t nb_cur;
    gox_pkg::nbr_t nb_emit;
    logic [CW-1:0] nb_cell;

    assign in_stall = (state_reg != gox_pkg::T_IDLE);
    assign accept   = in_valid && !in_stall;
    assign active   = (phase_reg == gox_pkg::PH_EXPLORE) || (phase_reg == gox_pkg::PH_FINAL);
    assign out_free = !out_valid_reg || !out_stall;
    assign mval     = mrdv_reg ? map_rdata : gox_pkg::MAP_UNKNOWN;
    assign nb_cur   = gox_pkg::neighbor(8'(cur_reg), head_reg, GRID_SIDE);
    assign nb_emit  = gox_pkg::neighbor(8'(cur_reg), sd_dir, GRID_SIDE);
    assign nb_cell  = CW'(nb_cur.loc);

    gox_ram #(.WIDTH(2), .DEPTH(CELLS)) u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    gox_search #(.GRID_SIDE(GRID_SIDE)) u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (srch_start),
        .from_cell (cur_reg),
        .to_cell   (tgt_reg),
        .init_we   (ipend_reg),
        .init_addr (iaddr_reg),
        .init_blk  (mval == gox_pkg::MAP_OBSTACLE),
        .sd_addr   (cur_reg),
        .sd_dir    (sd_dir),
        .stat      (srch)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gox_pkg::T_IDLE:
                if (accept)
                begin
                    priority if (op == gox_pkg::OP_START)
                        state_next = gox_pkg::T_START2;
                    else if (!active)
                        state_next = gox_pkg::T_FIN;
                    else if (!nb_cur.ok)
                        state_next = gox_pkg::T_SCAN_RD;
                    else if (distance < thr_reg)
                        state_next = gox_pkg::T_SCAN_RD;
                    else if (nb_cell == tgt_reg)
                        state_next = gox_pkg::T_SCAN_RD;
                    else
                        state_next = gox_pkg::T_EMIT_RD;
                end
            gox_pkg::T_START2:
                state_next = gox_pkg::T_SCAN_RD;
            gox_pkg::T_SCAN_RD:
                state_next = gox_pkg::T_SCAN_CHK;
            gox_pkg::T_SCAN_CHK:
                priority if (mval == gox_pkg::MAP_UNKNOWN)
                    state_next = gox_pkg::T_INIT;
                else if (scan_reg != CW'(CELLS - 1))
                    state_next = gox_pkg::T_SCAN_RD;
                else if (cur_reg == goal_reg)
                    state_next = gox_pkg::T_FIN;
                else
                    state_next = gox_pkg::T_INIT;
            gox_pkg::T_INIT:
                if (init_reg == (CW+1)'(CELLS))
                    state_next = gox_pkg::T_GO;
            gox_pkg::T_GO:
                state_next = gox_pkg::T_SEARCH;
            gox_pkg::T_SEARCH:
                if (srch.done)
                begin
                    priority if (srch.found)
                        state_next = gox_pkg::T_EMIT_RD;
                    else if (final_reg)
                        state_next = gox_pkg::T_FIN;
                    else
                        state_next = gox_pkg::T_SCAN_RD;
                end
            gox_pkg::T_EMIT_RD:
                state_next = gox_pkg::T_EMIT;
            gox_pkg::T_EMIT:
                state_next = gox_pkg::T_FIN;
            gox_pkg::T_FIN:
                if (out_free)
                    state_next = gox_pkg::T_IDLE;
            default:
                state_next = gox_pkg::T_IDLE;
        endcase
    end

    always_comb
    begin
        phase_next   = phase_reg;
        cur_next     = cur_reg;
        tgt_next     = tgt_reg;
        goal_next    = goal_reg;
        head_next    = head_reg;
        unreach_next = unreach_reg;
        scan_next    = scan_reg;
        init_next    = init_reg;
        final_next   = final_reg;
        rcell_next   = rcell_reg;
        rstat_next   = rstat_reg;
        pcell_next   = pcell_reg;
        pvalid_next  = pvalid_reg;
        phead_next   = phead_reg;
        ipend_next   = 1'b0;
        map_we       = 1'b0;
        map_waddr    = cur_reg;
        map_wdata    = gox_pkg::MAP_FREE;
        map_raddr    = scan_reg;
        srch_start   = 1'b0;
        load_out     = 1'b0;
        unique case (state_reg)
            gox_pkg::T_IDLE:
                if (accept)
                begin
                    rcell_next  = 4'd0;
                    rstat_next  = gox_pkg::RPT_NONE;
                    pcell_next  = 4'd0;
                    pvalid_next = 1'b0;
                    phead_next  = 2'd0;
                    scan_next   = '0;
                    if (op == gox_pkg::OP_START)
                    begin
                        cur_next     = cell_mod(start_cell);
                        goal_next    = cell_mod(goal_cell);
                        unreach_next = 1'b0;
                        map_we       = 1'b1;
                        map_waddr    = cell_mod(start_cell);
                    end
                    else if (active && nb_cur.ok)
                    begin
                        map_we     = 1'b1;
                        map_waddr  = nb_cell;
                        rcell_next = 4'(nb_cell);
                        if (distance < thr_reg)
                        begin
                            map_wdata  = gox_pkg::MAP_OBSTACLE;
                            rstat_next = gox_pkg::RPT_OBSTACLE;
                        end
                        else
                        begin
                            rstat_next = gox_pkg::RPT_FREE;
                            cur_next   = nb_cell;
                        end
                    end
                end
            gox_pkg::T_START2:
            begin
                map_we    = 1'b1;
                map_waddr = goal_reg;
            end
            gox_pkg::T_SCAN_RD:
                map_raddr = scan_reg;
            gox_pkg::T_SCAN_CHK:
            begin
                init_next = '0;
                priority if (mval == gox_pkg::MAP_UNKNOWN)
                begin
                    tgt_next   = scan_reg;
                    final_next = 1'b0;
                end
                else if (scan_reg != CW'(CELLS - 1))
                    scan_next = scan_reg + CW'(1);
                else
                begin
                    tgt_next   = goal_reg;
                    final_next = 1'b1;
                    if (cur_reg == goal_reg)
                        phase_next = gox_pkg::PH_DONE;
                end
            end
            gox_pkg::T_INIT:
                if (init_reg != (CW+1)'(CELLS))
                begin
                    map_raddr  = CW'(init_reg);
                    ipend_next = 1'b1;
                    init_next  = init_reg + (CW+1)'(1);
                end
            gox_pkg::T_GO:
                srch_start = 1'b1;
            gox_pkg::T_SEARCH:
                if (srch.done)
                begin
                    priority if (srch.found)
                        phase_next = final_reg ? gox_pkg::PH_FINAL : gox_pkg::PH_EXPLORE;
                    else if (final_reg)
                    begin
                        phase_next   = gox_pkg::PH_DONE;
                        unreach_next = 1'b1;
                    end
                    else
                    begin
                        map_we    = 1'b1;
                        map_waddr = tgt_reg;
                        map_wdata = gox_pkg::MAP_UNREACH;
                    end
                end
            gox_pkg::T_EMIT_RD:
                map_raddr = scan_reg;
            gox_pkg::T_EMIT:
            begin
                head_next = sd_dir;
                if (nb_emit.ok)
                begin
                    pcell_next  = 4'(CW'(nb_emit.loc));
                    pvalid_next = 1'b1;
                    phead_next  = sd_dir;
                end
            end
            gox_pkg::T_FIN:
                load_out = out_free;
            default:
                load_out = 1'b0;
        endcase
    end

    always_comb
    begin
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gox_pkg::T_IDLE;
            phase_reg     <= gox_pkg::PH_IDLE;
            cur_reg       <= '0;
            tgt_reg       <= '0;
            goal_reg      <= '0;
            head_reg      <= gox_pkg::HEAD_UP;
            unreach_reg   <= 1'b0;
            thr_reg       <= gox_pkg::THRESH_RESET;
            ipend_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            mvld_reg      <= '0;
            mrdv_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cur_reg       <= cur_next;
            tgt_reg       <= tgt_next;
            goal_reg      <= goal_next;
            head_reg      <= head_next;
            unreach_reg   <= unreach_next;
            ipend_reg     <= ipend_next;
            out_valid_reg <= out_valid_next;
            mrdv_reg      <= mvld_reg[map_raddr];
            if (cfg_we)
                thr_reg <= cfg_wdata;
            if (map_we)
                mvld_reg[map_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg   <= scan_next;
        init_reg   <= init_next;
        iaddr_reg  <= map_raddr;
        final_reg  <= final_next;
        rcell_reg  <= rcell_next;
        rstat_reg  <= rstat_next;
        pcell_reg  <= pcell_next;
        pvalid_reg <= pvalid_next;
        phead_reg  <= phead_next;
        if (load_out)
        begin
            o_rcell_reg   <= rcell_reg;
            o_rstat_reg   <= rstat_reg;
            o_pcell_reg   <= pcell_reg;
            o_pvalid_reg  <= pvalid_reg;
            o_phead_reg   <= phead_reg;
            o_done_reg    <= (phase_reg == gox_pkg::PH_DONE);
            o_unreach_reg <= unreach_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign reported_cell    = o_rcell_reg;
    assign reported_status  = o_rstat_reg;
    assign probe_cell       = o_pcell_reg;
    assign probe_valid      = o_pvalid_reg;
    assign heading          = o_phead_reg;
    assign done_res         = o_done_reg;
    assign goal_unreachable = o_unreach_reg;

endmodule

/* sv/gox_checker.sv */
`include "grid_obstacle_explorer_assert.svh"

module gox_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [3:0] reported_cell,
    input logic [1:0] reported_status,
    input logic [3:0] probe_cell,
    input logic       probe_valid,
    input logic [1:0] heading,
    input logic       done_res,
    input logic       goal_unreachable
);

    `GOX_ASSERT_NOW(a_probe_idle_zero, out_valid && !probe_valid, (probe_cell == 4'd0) && (heading == 2'd0))
    `GOX_ASSERT_NOW(a_unreach_done, out_valid && goal_unreachable, done_res)
    `GOX_ASSERT_NOW(a_done_no_probe, out_valid && done_res, !probe_valid)
    `GOX_ASSERT_NOW(a_report_code, out_valid, (reported_status <= gox_pkg::RPT_FREE) && ((reported_status != gox_pkg::RPT_NONE) || (reported_cell == 4'd0)))
    `GOX_ASSERT_NEXT(a_hold_result, out_valid && out_stall, out_valid && $stable(reported_cell) && $stable(probe_cell))

endmodule

bind grid_obstacle_explorer gox_checker u_gox_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .reported_cell    (reported_cell),
    .reported_status  (reported_status),
    .probe_cell       (probe_cell),
    .probe_valid      (probe_valid),
    .heading          (heading),
    .done_res         (done_res),
    .goal_unreachable (goal_unreachable)
);
